[sv/acp_pkg.sv]
// Shared types, codes and lookup tables of the CSI text parser.
package acp_pkg;

    localparam int MAX_RESULTS = 15;
    localparam int SLOTS       = 4;

    localparam logic [2:0] KIND_GLYPH  = 3'd0;
    localparam logic [2:0] KIND_LINE   = 3'd1;
    localparam logic [2:0] KIND_LOCATE = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_FLUSH  = 3'd4;
    localparam logic [2:0] KIND_COLOR  = 3'd5;

    localparam logic [2:0] PH_TEXT   = 3'd0;
    localparam logic [2:0] PH_ESC    = 3'd1;
    localparam logic [2:0] PH_OPEN   = 3'd2;
    localparam logic [2:0] PH_PARAMS = 3'd3;
    localparam logic [2:0] PH_CMD    = 3'd4;

    localparam logic [3:0] SGR_NONE   = 4'd15;
    localparam logic [3:0] COLOR_INIT = 4'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] glyph;
        logic [7:0] row;
        logic [7:0] col;
    } slot_t;

    // One queue entry: up to four fixed results, then a run of tab spaces.
    typedef struct packed {
        slot_t [SLOTS-1:0] slots;
        logic [2:0]        nf;
        logic [3:0]        tcnt;
        logic [7:0]        trow;
        logic [7:0]        tcol;
        logic [3:0]        color;
    } entry_t;

    localparam logic [15:0] HI_CP [0:127] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    function automatic logic [23:0] cga_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = {8'd0,   8'd0,   8'd0};
            4'd1:    rgb = {8'd0,   8'd0,   8'd170};
            4'd2:    rgb = {8'd0,   8'd170, 8'd0};
            4'd3:    rgb = {8'd0,   8'd170, 8'd170};
            4'd4:    rgb = {8'd170, 8'd0,   8'd0};
            4'd5:    rgb = {8'd170, 8'd0,   8'd170};
            4'd6:    rgb = {8'd170, 8'd170, 8'd0};
            4'd7:    rgb = {8'd170, 8'd170, 8'd170};
            4'd8:    rgb = {8'd85,  8'd85,  8'd85};
            4'd9:    rgb = {8'd85,  8'd85,  8'd255};
            4'd10:   rgb = {8'd85,  8'd255, 8'd85};
            4'd11:   rgb = {8'd85,  8'd255, 8'd255};
            4'd12:   rgb = {8'd255, 8'd85,  8'd85};
            4'd13:   rgb = {8'd255, 8'd85,  8'd255};
            4'd14:   rgb = {8'd255, 8'd255, 8'd85};
            default: rgb = {8'd255, 8'd255, 8'd255};
        endcase
        return rgb;
    endfunction

endpackage

[sv/acp_front.sv]
// Front end: accepts text bytes, runs the CSI parser and cursor state, builds queue entries.
module acp_front #(
    parameter int TAB_WIDTH  = 14,
    parameter int MAX_PARAMS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          text_byte,
    input  logic                q_full,
    output logic                push,
    output acp_pkg::entry_t     push_entry
);

    localparam int CW    = $clog2(MAX_PARAMS + 1);
    localparam int RECIP = (65536 + TAB_WIDTH - 1) / TAB_WIDTH;

    logic [2:0]    phase_reg, phase_next;
    logic [CW-1:0] pcnt_reg, pcnt_next;
    logic [15:0]   pval_reg, pval_next;
    logic [15:0]   p1_reg, p1_next;
    logic [15:0]   p2_reg, p2_next;
    logic [3:0]    sgr_reg, sgr_next;
    logic [7:0]    row_reg, row_next;
    logic [7:0]    col_reg, col_next;
    logic [3:0]    color_reg, color_next;
    logic          part_reg, part_next;

    acp_pkg::entry_t e;
    logic          accept;
    logic          do_text, do_cmd;
    logic [19:0]   acc;
    logic [15:0]   v;
    logic [7:0]    r, k, cm1, q, rem;
    logic [24:0]   prod;
    logic [15:0]   qt;
    logic [6:0]    cnt7, lim;
    logic [8:0]    csum;
    logic [15:0]   cp;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        pcnt_next  = pcnt_reg;
        pval_next  = pval_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        sgr_next   = sgr_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        color_next = color_reg;
        part_next  = part_reg;
        e          = '0;
        do_text    = 1'b0;
        do_cmd     = 1'b0;
        acc        = '0;
        v          = '0;
        r          = '0;
        k          = '0;
        cm1        = '0;
        q          = '0;
        rem        = '0;
        prod       = '0;
        qt         = '0;
        cnt7       = '0;
        lim        = '0;
        csum       = '0;
        cp         = '0;

        if (text_byte != 8'd0)
        begin
            case (phase_reg)
                acp_pkg::PH_ESC:
                begin
                    if (text_byte == 8'h5B)
                    begin
                        phase_next = acp_pkg::PH_OPEN;
                        pcnt_next  = '0;
                        pval_next  = '0;
                        p1_next    = '0;
                        p2_next    = '0;
                        sgr_next   = acp_pkg::SGR_NONE;
                    end
                    else
                    begin
                        phase_next = acp_pkg::PH_TEXT;
                        e.slots[0] = '{acp_pkg::KIND_GLYPH, 8'h1B, row_next, col_next};
                        e.nf       = 3'd1;
                        col_next   = (col_next == 8'd255) ? 8'd255 : col_next + 8'd1;
                        part_next  = 1'b1;
                        do_text    = 1'b1;
                    end
                end
                acp_pkg::PH_OPEN, acp_pkg::PH_PARAMS:
                begin
                    phase_next = acp_pkg::PH_PARAMS;
                    if (phase_reg == acp_pkg::PH_OPEN && text_byte == 8'h3F)
                    begin
                        phase_next = acp_pkg::PH_PARAMS;
                    end
                    else if (text_byte inside {[8'h30:8'h39]})
                    begin
                        acc       = 20'(pval_reg) * 20'd10 + 20'(text_byte - 8'h30);
                        pval_next = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                    end
                    else
                    begin
                        // Close the parameter under way.
                        v = pval_reg;
                        if (pcnt_reg == CW'(0))
                            p1_next = v;
                        if (pcnt_reg == CW'(1))
                            p2_next = v;
                        if (v == 16'd0)
                            sgr_next = 4'd7;
                        else if (v >= 16'd30 && v <= 16'd37)
                            sgr_next = 4'(v - 16'd30);
                        pcnt_next = pcnt_reg + CW'(1);
                        pval_next = '0;
                        if (text_byte == 8'h3B)
                        begin
                            if (pcnt_next >= CW'(MAX_PARAMS))
                                phase_next = acp_pkg::PH_CMD;
                        end
                        else
                        begin
                            do_cmd = 1'b1;
                        end
                    end
                end
                acp_pkg::PH_CMD:
                begin
                    do_cmd = 1'b1;
                end
                default:
                begin
                    phase_next = acp_pkg::PH_TEXT;
                    do_text    = 1'b1;
                end
            endcase

            if (do_cmd)
            begin
                phase_next = acp_pkg::PH_TEXT;
                if (text_byte == 8'h48 || text_byte == 8'h66)
                begin
                    r = (p1_next == 16'd0) ? 8'd1 : (p1_next > 16'd255) ? 8'd255 : p1_next[7:0];
                    k = (p2_next == 16'd0) ? 8'd1 : (p2_next > 16'd255) ? 8'd255 : p2_next[7:0];
                    if (part_next && r != row_next)
                    begin
                        e.slots[e.nf[1:0]] = '{acp_pkg::KIND_LINE, 8'd0, row_next, col_next};
                        e.nf     = e.nf + 3'd1;
                        row_next = (row_next == 8'd255) ? 8'd255 : row_next + 8'd1;
                        col_next = 8'd1;
                    end
                    else if (part_next)
                    begin
                        e.slots[e.nf[1:0]] = '{acp_pkg::KIND_FLUSH, 8'd0, row_next, col_next};
                        e.nf = e.nf + 3'd1;
                    end
                    if (r != row_next)
                    begin
                        row_next = r;
                        col_next = 8'd1;
                    end
                    part_next = (k > col_next);
                    col_next  = k;
                    e.slots[e.nf[1:0]] = '{acp_pkg::KIND_LOCATE, 8'd0, row_next, col_next};
                    e.nf = e.nf + 3'd1;
                end
                else if (text_byte == 8'h4A)
                begin
                    if (p1_next == 16'd2)
                    begin
                        row_next  = 8'd1;
                        col_next  = 8'd1;
                        part_next = 1'b0;
                        e.slots[e.nf[1:0]] = '{acp_pkg::KIND_CLEAR, 8'd0, 8'd1, 8'd1};
                        e.nf = e.nf + 3'd1;
                    end
                end
                else if (text_byte == 8'h4B)
                begin
                    part_next = 1'b0;
                    e.slots[e.nf[1:0]] = '{acp_pkg::KIND_FLUSH, 8'd0, row_next, col_next};
                    e.nf = e.nf + 3'd1;
                end
                else if (text_byte == 8'h6D)
                begin
                    if (sgr_next != acp_pkg::SGR_NONE)
                    begin
                        color_next = sgr_next;
                        e.slots[e.nf[1:0]] = '{acp_pkg::KIND_COLOR, 8'd0, row_next, col_next};
                        e.nf = e.nf + 3'd1;
                    end
                end
            end

            if (do_text)
            begin
                if (text_byte == 8'h1B)
                begin
                    phase_next = acp_pkg::PH_ESC;
                end
                else if (text_byte == 8'h0A)
                begin
                    e.slots[e.nf[1:0]] = '{acp_pkg::KIND_LINE, 8'd0, row_next, col_next};
                    e.nf      = e.nf + 3'd1;
                    row_next  = (row_next == 8'd255) ? 8'd255 : row_next + 8'd1;
                    col_next  = 8'd1;
                    part_next = 1'b0;
                end
                else if (text_byte == 8'h09)
                begin
                    // Distance to the next stop: TAB_WIDTH - ((col-1) mod TAB_WIDTH), the mod by reciprocal.
                    cm1  = col_next - 8'd1;
                    prod = 25'(cm1) * 25'(RECIP);
                    q    = prod[23:16];
                    qt   = 16'(q) * 16'(TAB_WIDTH);
                    rem  = 8'(16'(cm1) - qt);
                    cnt7 = 7'(TAB_WIDTH) - rem[6:0];
                    lim  = 7'(acp_pkg::MAX_RESULTS) - 7'(e.nf);
                    if (cnt7 > lim)
                        cnt7 = lim;
                    e.tcnt    = cnt7[3:0];
                    e.trow    = row_next;
                    e.tcol    = col_next;
                    csum      = 9'(col_next) + 9'(cnt7);
                    col_next  = (csum > 9'd255) ? 8'd255 : csum[7:0];
                    part_next = 1'b1;
                end
                else if (text_byte[7])
                begin
                    cp = acp_pkg::HI_CP[text_byte[6:0]];
                    if (cp < 16'h0800)
                    begin
                        e.slots[e.nf[1:0]] = '{acp_pkg::KIND_GLYPH, {3'b110, cp[10:6]},
                                               row_next, col_next};
                        e.nf = e.nf + 3'd1;
                    end
                    else
                    begin
                        e.slots[e.nf[1:0]] = '{acp_pkg::KIND_GLYPH, {4'b1110, cp[15:12]},
                                               row_next, col_next};
                        e.nf = e.nf + 3'd1;
                        e.slots[e.nf[1:0]] = '{acp_pkg::KIND_GLYPH, {2'b10, cp[11:6]},
                                               row_next, col_next};
                        e.nf = e.nf + 3'd1;
                    end
                    e.slots[e.nf[1:0]] = '{acp_pkg::KIND_GLYPH, {2'b10, cp[5:0]},
                                           row_next, col_next};
                    e.nf      = e.nf + 3'd1;
                    col_next  = (col_next == 8'd255) ? 8'd255 : col_next + 8'd1;
                    part_next = 1'b1;
                end
                else
                begin
                    e.slots[e.nf[1:0]] = '{acp_pkg::KIND_GLYPH, text_byte, row_next, col_next};
                    e.nf      = e.nf + 3'd1;
                    col_next  = (col_next == 8'd255) ? 8'd255 : col_next + 8'd1;
                    part_next = 1'b1;
                end
            end
        end
        e.color = color_next;
    end

    assign push       = accept && (e.nf != 3'd0 || e.tcnt != 4'd0);
    assign push_entry = e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= acp_pkg::PH_TEXT;
            pcnt_reg  <= '0;
            pval_reg  <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            sgr_reg   <= acp_pkg::SGR_NONE;
            row_reg   <= 8'd1;
            col_reg   <= 8'd1;
            color_reg <= acp_pkg::COLOR_INIT;
            part_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pcnt_reg  <= pcnt_next;
            pval_reg  <= pval_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            sgr_reg   <= sgr_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            color_reg <= color_next;
            part_reg  <= part_next;
        end
    end

endmodule

[sv/acp_queue.sv]
// Two-entry queue between the parser front end and the result expander.
module acp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  acp_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output acp_pkg::entry_t head
);

    acp_pkg::entry_t mem_reg [0:1];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

[sv/acp_back.sv]
// Back end: expands entries into registered result items, one per cycle unless stalled.
module acp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  acp_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      kind,
    output logic [7:0]      glyph_byte,
    output logic [7:0]      cursor_row_out,
    output logic [7:0]      cursor_col_out,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic            last
);

    logic [4:0]  idx_reg, idx_next;
    logic        vld_reg;
    acp_pkg::slot_t res_reg, res;
    logic [23:0] rgb_reg;
    logic        last_reg;
    logic        load, is_last;
    logic [4:0]  total, off;
    logic [8:0]  csum;

    always_comb
    begin
        total   = 5'(head.nf) + 5'(head.tcnt);
        is_last = (idx_reg == total - 5'd1);
        off     = idx_reg - 5'(head.nf);
        csum    = 9'(head.tcol) + 9'(off);
        if (idx_reg < 5'(head.nf))
            res = head.slots[idx_reg[1:0]];
        else
            res = '{acp_pkg::KIND_GLYPH, 8'h20, head.trow,
                    (csum > 9'd255) ? 8'd255 : csum[7:0]};
        load     = q_not_empty && (!vld_reg || out_ready);
        pop      = load && is_last;
        idx_next = pop ? 5'd0 : idx_reg + 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= res;
            rgb_reg  <= acp_pkg::cga_rgb(head.color);
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 5'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= idx_next;
            if (load)
                vld_reg <= 1'b1;
            else if (out_ready)
                vld_reg <= 1'b0;
        end
    end

    assign out_valid      = vld_reg;
    assign kind           = res_reg.kind;
    assign glyph_byte     = res_reg.glyph;
    assign cursor_row_out = res_reg.row;
    assign cursor_col_out = res_reg.col;
    assign red            = rgb_reg[23:16];
    assign green          = rgb_reg[15:8];
    assign blue           = rgb_reg[7:0];
    assign last           = last_reg;

endmodule

[sv/ansi_csi_text_parser.sv]
// Top level of the CSI text parser: front end, entry queue and result expander.
//
// The block takes one byte of a text stream per cycle and turns it into result
// items for a line-store consumer: glyph bytes at the cursor, line ends, and
// locate, clear, flush and color commands from ESC [ sequences, each result
// carrying the current foreground color in CGA RGB. A byte is accepted in any
// cycle in which the two-entry queue between the parser and the expander has
// room, so a stream of bytes that each cause at most one result flows at one
// byte per cycle while the output is not stalled. The expander delivers one
// result item per cycle through its output register while the output is not
// stalled, so a byte that causes n results (a tab run, a CP437 byte that
// becomes two or three UTF-8 bytes, a locate that first ends a line) holds
// the expander until all n are out, and bytes that cause no result (escape
// and parameter bytes) never enter the queue. The item marked last is the
// final result of its input byte. The line store is left to the consumer.
module ansi_csi_text_parser #(
    parameter int TAB_WIDTH  = 14,
    parameter int MAX_PARAMS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] glyph_byte,
    output logic [7:0] cursor_row_out,
    output logic [7:0] cursor_col_out,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       last
);

    logic            push, full, pop, not_empty;
    acp_pkg::entry_t push_entry, head;

    // Parser and cursor state live in the front end.
    acp_front #(
        .TAB_WIDTH  (TAB_WIDTH),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .q_full     (full),
        .push       (push),
        .push_entry (push_entry)
    );

    // The queue lets the front keep parsing while a long expansion drains.
    acp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    // The back end walks each entry one result per cycle while the output is not stalled.
    acp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (not_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .glyph_byte     (glyph_byte),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .last           (last)
    );

`ifndef SYNTHESIS
    a_glyph_only_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != acp_pkg::KIND_GLYPH |-> glyph_byte == 8'd0)
        else $error("command result carries a glyph byte");
    a_cursor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_row_out != 8'd0 && cursor_col_out != 8'd0)
        else $error("result cursor is zero");
    a_command_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == acp_pkg::KIND_LOCATE || kind == acp_pkg::KIND_CLEAR
                      || kind == acp_pkg::KIND_COLOR) |-> last)
        else $error("locate, clear or color result not last of its item");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for the CSI text parser: directed and random byte streams.
module testbench;

    localparam int TAB_STOP   = 14;
    localparam int PARAM_MAX  = 16;
    localparam int STALL_LIMIT = 5000;

    // CGA palette as {red, green, blue}.
    localparam logic [23:0] PALETTE [0:15] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAAAA00, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    typedef struct {
        logic [2:0] kind;
        logic [7:0] glyph;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } console_result_t;

    // Scoreboard: holds its own copy of the parser state and the results that are
    // still owed by the block, oldest first.
    class console_scoreboard;
        console_result_t owed[$];
        console_result_t step_q[$];
        int errors;
        logic [2:0] phase;
        int pcount, pval, p1, p2, row, col;
        logic [3:0] sgr, color;
        bit partial;

        function new();
            errors = 0;
            phase = acp_pkg::PH_TEXT;
            pcount = 0; pval = 0; p1 = 0; p2 = 0;
            sgr = acp_pkg::SGR_NONE;
            row = 1; col = 1;
            color = acp_pkg::COLOR_INIT;
            partial = 0;
        endfunction

        function int bump(int v);
            return (v < 255) ? v + 1 : 255;
        endfunction

        function void put(logic [2:0] k, logic [7:0] g, int r, int c);
            console_result_t res;
            if (step_q.size() >= acp_pkg::MAX_RESULTS) return;
            res.kind = k;
            res.glyph = g;
            res.row = r[7:0];
            res.col = c[7:0];
            {res.red, res.green, res.blue} = PALETTE[color];
            res.last = 1'b0;
            step_q.insert(step_q.size(), res);
        endfunction

        function void place(logic [7:0] g);
            put(acp_pkg::KIND_GLYPH, g, row, col);
            col = bump(col);
            partial = 1;
        endfunction

        function void close_param();
            if (pcount == 0) p1 = pval;
            if (pcount == 1) p2 = pval;
            if (pval == 0) sgr = 4'd7;
            else if (pval >= 30 && pval <= 37) sgr = 4'(pval - 30);
            pcount++;
            pval = 0;
        endfunction

        function void run_command(logic [7:0] c);
            int r, k;
            phase = acp_pkg::PH_TEXT;
            if (c == "H" || c == "f") begin
                r = (p1 == 0) ? 1 : ((p1 > 255) ? 255 : p1);
                k = (p2 == 0) ? 1 : ((p2 > 255) ? 255 : p2);
                // A partial line is ended when the target row differs, else flushed.
                if (partial && r != row) begin
                    put(acp_pkg::KIND_LINE, 8'd0, row, col);
                    row = bump(row);
                    col = 1;
                end
                else if (partial) begin
                    put(acp_pkg::KIND_FLUSH, 8'd0, row, col);
                end
                if (r != row) begin
                    row = r;
                    col = 1;
                end
                partial = (k > col);
                col = k;
                put(acp_pkg::KIND_LOCATE, 8'd0, row, col);
            end
            else if (c == "J") begin
                if (p1 == 2) begin
                    row = 1; col = 1; partial = 0;
                    put(acp_pkg::KIND_CLEAR, 8'd0, row, col);
                end
            end
            else if (c == "K") begin
                partial = 0;
                put(acp_pkg::KIND_FLUSH, 8'd0, row, col);
            end
            else if (c == "m") begin
                if (sgr != acp_pkg::SGR_NONE) begin
                    color = sgr;
                    put(acp_pkg::KIND_COLOR, 8'd0, row, col);
                end
            end
        endfunction

        function void plain_text(logic [7:0] b);
            int cnt;
            logic [15:0] cp;
            if (b == 8'h1B) begin
                phase = acp_pkg::PH_ESC;
            end
            else if (b == 8'h0A) begin
                put(acp_pkg::KIND_LINE, 8'd0, row, col);
                row = bump(row);
                col = 1;
                partial = 0;
            end
            else if (b == 8'h09) begin
                cnt = TAB_STOP - ((col - 1) % TAB_STOP);
                if (acp_pkg::MAX_RESULTS - step_q.size() < cnt)
                    cnt = acp_pkg::MAX_RESULTS - step_q.size();
                for (int i = 0; i < cnt; i++) place(8'h20);
            end
            else if (b >= 8'd128) begin
                cp = acp_pkg::HI_CP[b[6:0]];
                if (cp < 16'h0800) begin
                    put(acp_pkg::KIND_GLYPH, 8'hC0 | 8'(cp >> 6), row, col);
                end
                else begin
                    put(acp_pkg::KIND_GLYPH, 8'hE0 | 8'(cp >> 12), row, col);
                    put(acp_pkg::KIND_GLYPH, 8'h80 | 8'((cp >> 6) & 16'h3F), row, col);
                end
                place(8'h80 | 8'(cp & 16'h3F));
            end
            else begin
                place(b);
            end
        endfunction

        // Called once per accepted input item; queues the results it causes.
        function void note_byte(logic [7:0] b);
            step_q.delete();
            if (b == 8'd0) return;
            case (phase)
                acp_pkg::PH_ESC: begin
                    if (b == "[") begin
                        phase = acp_pkg::PH_OPEN;
                        pcount = 0; pval = 0; p1 = 0; p2 = 0;
                        sgr = acp_pkg::SGR_NONE;
                    end
                    else begin
                        // A lone escape goes out as a glyph, then the byte is text.
                        phase = acp_pkg::PH_TEXT;
                        place(8'h1B);
                        plain_text(b);
                    end
                end
                acp_pkg::PH_OPEN, acp_pkg::PH_PARAMS: begin
                    if (phase == acp_pkg::PH_OPEN && b == "?") begin
                        phase = acp_pkg::PH_PARAMS;
                    end
                    else begin
                        phase = acp_pkg::PH_PARAMS;
                        if (b >= "0" && b <= "9") begin
                            pval = pval * 10 + (b - "0");
                            if (pval > 65535) pval = 65535;
                        end
                        else if (b == ";") begin
                            close_param();
                            if (pcount >= PARAM_MAX) phase = acp_pkg::PH_CMD;
                        end
                        else begin
                            close_param();
                            run_command(b);
                        end
                    end
                end
                acp_pkg::PH_CMD: run_command(b);
                default: begin
                    phase = acp_pkg::PH_TEXT;
                    plain_text(b);
                end
            endcase
            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i]) owed.insert(owed.size(), step_q[i]);
        endfunction

        function void check_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(console_result_t got);
            console_result_t exp_r;
            if (owed.size() == 0) begin
                $error("result item with nothing expected: kind %0d", got.kind);
                errors++;
                return;
            end
            exp_r = owed.pop_front();
            check_field("kind", exp_r.kind, got.kind);
            check_field("glyph_byte", exp_r.glyph, got.glyph);
            check_field("cursor_row_out", exp_r.row, got.row);
            check_field("cursor_col_out", exp_r.col, got.col);
            check_field("red", exp_r.red, got.red);
            check_field("green", exp_r.green, got.green);
            check_field("blue", exp_r.blue, got.blue);
            check_field("last", exp_r.last, got.last);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte = 8'h41;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] kind;
    logic [7:0] glyph_byte, cursor_row_out, cursor_col_out, red, green, blue;
    logic       last;

    console_scoreboard sb = new();
    bit idling = 1'b1;
    bit paused = 1'b0;
    int quiet_cycles = 0;
    int n_sent = 0;

    ansi_csi_text_parser dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .glyph_byte(glyph_byte),
        .cursor_row_out(cursor_row_out), .cursor_col_out(cursor_col_out),
        .red(red), .green(green), .blue(blue), .last(last)
    );

    always #10 clk = ~clk;

    // The receiver stalls at random, about 31 percent of the time, unless idling is off.
    always @(posedge clk) begin
        out_ready <= !(idling && $urandom_range(99) < 31);
    end

    // Every accepted result item is checked against the oldest expectation.
    always @(posedge clk) begin
        console_result_t got;
        if (rst_n && out_valid && out_ready) begin
            got.kind = kind;
            got.glyph = glyph_byte;
            got.row = cursor_row_out;
            got.col = cursor_col_out;
            got.red = red;
            got.green = green;
            got.blue = blue;
            got.last = last;
            sb.check_result(got);
        end
    end

    // The watchdog ends the run if no item moves on either side for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ansi_csi_text_parser regression: fail");
                $finish;
            end
        end
    end

    // Valid is only lowered inside an idle gap or a drain, so it never drops and rises in one step.
    task automatic send_byte(input logic [7:0] b);
        while (idling && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(b);
        n_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_number(input int v);
        send_text($sformatf("%0d", v));
    endtask

    // A random but well-formed escape sequence with a random command byte.
    task automatic send_random_csi();
        int n;
        logic [7:0] cmds [0:6] = '{"H", "f", "J", "K", "m", "z", "A"};
        send_byte(8'h1B);
        send_byte("[");
        if ($urandom_range(7) == 0) send_byte("?");
        n = $urandom_range(3);
        if ($urandom_range(15) == 0) n = PARAM_MAX + 1;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(5))
                0: ;
                1: send_number(2);
                2: send_number($urandom_range(30, 47));
                3: send_number($urandom_range(300));
                4: send_number($urandom_range(99999));
                default: send_number($urandom_range(9));
            endcase
            if (i < n - 1) send_byte(";");
        end
        send_byte(cmds[$urandom_range(6)]);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, the H, K, m and J commands and the odd cases.
        send_byte(8'd1);
        send_byte(8'd255);
        send_byte(8'h80);
        send_byte(8'h9E);
        send_text("A\tB\n");
        send_text("\033x\033\033[?5;7H");
        send_text("\033[300;0H\033[K");
        send_text("\033[0;31;44m\033[99999m\033[2J\033[3J\033[5z");
        send_text("\033[;;;;;;;;;;;;;;;;Q");
        send_text("\033[255;250H\t\t\n\n");

        while (n_sent < 465) begin
            // A stretch with no idling on either side.
            idling = !(n_sent >= 150 && n_sent < 250);
            if (!paused && n_sent >= 320) begin
                wait_drained();
                paused = 1'b1;
            end
            case ($urandom_range(9))
                0, 1: begin
                    send_random_csi();
                end
                2: begin
                    send_byte(8'h09);
                end
                3: begin
                    send_byte(8'h0A);
                end
                4: begin
                    send_byte(8'($urandom_range(128, 255)));
                end
                5: begin
                    // A broken sequence: an escape followed by a random byte.
                    send_byte(8'h1B);
                    send_byte(8'($urandom_range(1, 255)));
                end
                6: begin
                    send_byte(8'($urandom_range(1, 255)));
                end
                default: begin
                    send_byte(8'($urandom_range(32, 126)));
                end
            endcase
        end
        // Line ends near the bottom row drive the row to saturation.
        idling = 1'b1;
        send_text("\033[254;1H");
        repeat (4) send_byte(8'h0A);

        wait_drained();
        if (sb.errors == 0) begin
            $display("ansi_csi_text_parser regression: pass");
        end
        else begin
            $display("ansi_csi_text_parser regression: fail");
        end
        $finish;
    end
endmodule
